// ===== sv/pllc_pkg.sv =====
// ----------------------------------------------------------------------------
// pllc_pkg: shared definitions for the playlist cursor block
// Command and status codes, default sizes and the memory control bundle
// that passes between the sequencer and the slot storage.
// ----------------------------------------------------------------------------
package pllc_pkg;

    localparam int DEF_SLOTS   = 64;
    localparam int DEF_ID_BITS = 32;

    typedef logic [2:0] t_act;
    typedef logic [2:0] t_status;

    localparam t_act ACT_INSERT = 3'd0;
    localparam t_act ACT_FIRST  = 3'd1;
    localparam t_act ACT_LAST   = 3'd2;
    localparam t_act ACT_NEXT   = 3'd3;
    localparam t_act ACT_PREV   = 3'd4;
    localparam t_act ACT_DELETE = 3'd5;

    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_NONE    = 3'd1;
    localparam t_status ST_ONLY    = 3'd2;
    localparam t_status ST_LAST    = 3'd3;
    localparam t_status ST_DELETED = 3'd4;
    localparam t_status ST_FULL    = 3'd5;

    // read and write enables for the slot storage
    typedef struct packed {
        logic link_re;
        logic trk_re;
        logic fs_re;
        logic trk_we;
        logic nxt_we;
        logic prv_we;
        logic fs_we;
    } t_mem_ctl;

endpackage

// ===== sv/pllc_slot_mem.sv =====
// ----------------------------------------------------------------------------
// pllc_slot_mem: slot table and free-slot stack
// Four single-port-write memories with registered reads: track identifier,
// next link, previous link and the free-slot stack.
// ----------------------------------------------------------------------------
module pllc_slot_mem #(
    parameter int SLOTS   = pllc_pkg::DEF_SLOTS,
    parameter int ID_BITS = pllc_pkg::DEF_ID_BITS,
    parameter int SW      = $clog2(SLOTS),
    parameter int LW      = $clog2(SLOTS + 1)
) (
    input  logic               i_clk,
    input  pllc_pkg::t_mem_ctl i_ctl,
    input  logic [SW-1:0]      i_link_raddr,
    input  logic [SW-1:0]      i_trk_raddr,
    input  logic [SW-1:0]      i_fs_raddr,
    input  logic [SW-1:0]      i_trk_waddr,
    input  logic [ID_BITS-1:0] i_trk_wdata,
    input  logic [SW-1:0]      i_nxt_waddr,
    input  logic [LW-1:0]      i_nxt_wdata,
    input  logic [SW-1:0]      i_prv_waddr,
    input  logic [LW-1:0]      i_prv_wdata,
    input  logic [SW-1:0]      i_fs_waddr,
    input  logic [SW-1:0]      i_fs_wdata,
    output logic [LW-1:0]      o_nxt_rd,
    output logic [LW-1:0]      o_prv_rd,
    output logic [ID_BITS-1:0] o_trk_rd,
    output logic [SW-1:0]      o_fs_rd
);
    import pllc_pkg::*;

    logic [ID_BITS-1:0] r_trk_mem [SLOTS];
    logic [LW-1:0]      r_nxt_mem [SLOTS];
    logic [LW-1:0]      r_prv_mem [SLOTS];
    logic [SW-1:0]      r_fs_mem  [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.trk_we) begin
            r_trk_mem[i_trk_waddr] <= i_trk_wdata;
        end
        if (i_ctl.trk_re) begin
            o_trk_rd <= r_trk_mem[i_trk_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.nxt_we) begin
            r_nxt_mem[i_nxt_waddr] <= i_nxt_wdata;
        end
        if (i_ctl.link_re) begin
            o_nxt_rd <= r_nxt_mem[i_link_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.prv_we) begin
            r_prv_mem[i_prv_waddr] <= i_prv_wdata;
        end
        if (i_ctl.link_re) begin
            o_prv_rd <= r_prv_mem[i_link_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fs_we) begin
            r_fs_mem[i_fs_waddr] <= i_fs_wdata;
        end
        if (i_ctl.fs_re) begin
            o_fs_rd <= r_fs_mem[i_fs_raddr];
        end
    end

endmodule

// ===== sv/playlist_linked_list_cursor.sv =====
// ----------------------------------------------------------------------------
// playlist_linked_list_cursor: doubly linked playlist with a play cursor
// Slot table in memory, free-slot stack, head/tail/cursor registers.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_action and i_track_id with start high; the beat
//   is taken at a rising edge where start is high and busy is low.
//   Result channel: o_done is high for exactly one cycle and the result
//   ports are valid in that cycle. The receiver cannot stall the block.
// Sequencing:
//   The result strobe comes in state S_TRK, after S_LINK; busy drops in the
//   same cycle the strobe falls, so a new command is taken only once the last
//   is through. The order is set by the read-modify-write chain on the link
//   memory: read the cursor links, compute and write the updated links while
//   reading the new cursor's track, then present the result.
// Reset:
//   Synchronous, active low. Head, tail and cursor go null, the free count
//   goes to SLOTS. The slot table is not cleared; the free stack is not
//   swept either: a low-water mark tells fresh stack entries (slot index
//   equals stack position) from pushed ones, so there is no clearing pass.
// ----------------------------------------------------------------------------
module playlist_linked_list_cursor #(
    parameter int SLOTS   = pllc_pkg::DEF_SLOTS,
    parameter int ID_BITS = pllc_pkg::DEF_ID_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pllc_pkg::t_act    i_action,
    input  logic [31:0]       i_track_id,
    output logic              o_done,
    output logic [31:0]       o_playing_id,
    output logic              o_list_empty,
    output pllc_pkg::t_status o_status,
    output logic [6:0]        o_entry_count
);
    import pllc_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam int CW = LW;
    localparam logic [LW-1:0] NIL       = LW'(SLOTS);
    localparam logic [CW-1:0] FREE_ALL  = CW'(SLOTS);
    localparam logic [CW-1:0] FREE_ONE  = CW'(SLOTS - 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LINK = 2'd1;
    localparam logic [1:0] S_TRK  = 2'd2;

    logic [1:0]         r_state,    n_state;
    t_act               r_action,   n_action;
    logic [ID_BITS-1:0] r_id,       n_id;
    logic [LW-1:0]      r_head,     n_head;
    logic [LW-1:0]      r_tail,     n_tail;
    logic [LW-1:0]      r_cursor,   n_cursor;
    logic [CW-1:0]      r_free,     n_free;
    logic [CW-1:0]      r_low,      n_low;
    t_status            r_status,   n_status;
    logic               r_use_id,   n_use_id;
    logic               r_pend_we,  n_pend_we;
    logic [SW-1:0]      r_pend_addr, n_pend_addr;
    logic [LW-1:0]      r_pend_data, n_pend_data;

    t_mem_ctl           mem_ctl;
    logic [SW-1:0]      link_raddr, trk_raddr, fs_raddr;
    logic [SW-1:0]      trk_waddr, nxt_waddr, prv_waddr, fs_waddr, fs_wdata;
    logic [ID_BITS-1:0] trk_wdata;
    logic [LW-1:0]      nxt_wdata, prv_wdata;
    logic [LW-1:0]      nxt_rd, prv_rd;
    logic [ID_BITS-1:0] trk_rd;
    logic [SW-1:0]      fs_rd;

    logic [ID_BITS+31:0] id_wide;
    logic [ID_BITS-1:0]  id_in;
    logic [ID_BITS-1:0]  play_sel;
    logic [ID_BITS+31:0] play_wide;
    logic [CW-1:0]       count;
    logic [CW+6:0]       count_wide;

    logic [CW-1:0] pop_idx;
    logic [SW-1:0] pop_slot;
    logic [LW-1:0] nc;

    function automatic logic is_slot(input logic [LW-1:0] v);
        return v < NIL;
    endfunction

    // fit the 32-bit port to the stored identifier width
    assign id_wide = {{ID_BITS{1'b0}}, i_track_id};
    assign id_in   = id_wide[ID_BITS-1:0];

    pllc_slot_mem #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS),
        .SW      (SW),
        .LW      (LW)
    ) u_mem (
        .i_clk        (i_clk),
        .i_ctl        (mem_ctl),
        .i_link_raddr (link_raddr),
        .i_trk_raddr  (trk_raddr),
        .i_fs_raddr   (fs_raddr),
        .i_trk_waddr  (trk_waddr),
        .i_trk_wdata  (trk_wdata),
        .i_nxt_waddr  (nxt_waddr),
        .i_nxt_wdata  (nxt_wdata),
        .i_prv_waddr  (prv_waddr),
        .i_prv_wdata  (prv_wdata),
        .i_fs_waddr   (fs_waddr),
        .i_fs_wdata   (fs_wdata),
        .o_nxt_rd     (nxt_rd),
        .o_prv_rd     (prv_rd),
        .o_trk_rd     (trk_rd),
        .o_fs_rd      (fs_rd)
    );

    // stack top; below the low-water mark the stack still holds its reset image
    assign pop_idx  = r_free - CW'(1);
    assign pop_slot = (pop_idx < r_low) ? pop_idx[SW-1:0] : fs_rd;

    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_id        = r_id;
        n_head      = r_head;
        n_tail      = r_tail;
        n_cursor    = r_cursor;
        n_free      = r_free;
        n_low       = r_low;
        n_status    = r_status;
        n_use_id    = r_use_id;
        n_pend_we   = r_pend_we;
        n_pend_addr = r_pend_addr;
        n_pend_data = r_pend_data;
        nc          = r_cursor;

        mem_ctl     = '0;
        link_raddr  = r_cursor[SW-1:0];
        fs_raddr    = pop_idx[SW-1:0];
        trk_raddr   = r_cursor[SW-1:0];
        trk_waddr   = pop_slot;
        trk_wdata   = r_id;
        nxt_waddr   = pop_slot;
        nxt_wdata   = NIL;
        prv_waddr   = pop_slot;
        prv_wdata   = NIL;
        fs_waddr    = r_free[SW-1:0];
        fs_wdata    = r_cursor[SW-1:0];

        case (r_state)
            S_IDLE: begin
                // take the beat and fetch cursor links and the stack top
                if (start) begin
                    n_state         = S_LINK;
                    n_action        = i_action;
                    n_id            = id_in;
                    mem_ctl.link_re = 1'b1;
                    mem_ctl.fs_re   = 1'b1;
                end
            end
            S_LINK: begin
                n_state   = S_TRK;
                n_status  = ST_OK;
                n_use_id  = 1'b0;
                n_pend_we = 1'b0;
                case (r_action)
                    ACT_INSERT: begin
                        if (r_free == '0) begin
                            n_status = ST_FULL;
                        end else begin
                            // pop a slot, write its record, link it after the tail
                            n_free = pop_idx;
                            if (pop_idx < r_low) begin
                                n_low = pop_idx;
                            end
                            mem_ctl.trk_we = 1'b1;
                            mem_ctl.nxt_we = 1'b1;
                            mem_ctl.prv_we = 1'b1;
                            if (is_slot(r_head) && is_slot(r_tail)) begin
                                prv_wdata   = r_tail;
                                n_pend_we   = 1'b1;
                                n_pend_addr = r_tail[SW-1:0];
                                n_pend_data = LW'(pop_slot);
                            end else begin
                                n_head = LW'(pop_slot);
                            end
                            n_tail   = LW'(pop_slot);
                            nc       = LW'(pop_slot);
                            n_use_id = 1'b1;
                        end
                    end
                    ACT_FIRST: begin
                        if (is_slot(r_cursor)) begin
                            nc = r_head;
                        end
                    end
                    ACT_LAST: begin
                        if (is_slot(r_cursor)) begin
                            nc = r_tail;
                        end
                    end
                    ACT_NEXT: begin
                        if (is_slot(r_cursor)) begin
                            nc = is_slot(nxt_rd) ? nxt_rd : r_head;
                        end
                    end
                    ACT_PREV: begin
                        if (is_slot(r_cursor)) begin
                            nc = is_slot(prv_rd) ? prv_rd : r_tail;
                        end
                    end
                    ACT_DELETE: begin
                        if (!is_slot(r_head) || !is_slot(r_cursor)) begin
                            n_status = ST_NONE;
                        end else begin
                            // return the cursor slot to the stack
                            if (r_free < FREE_ALL) begin
                                mem_ctl.fs_we = 1'b1;
                                n_free        = r_free + CW'(1);
                            end
                            if (r_free == FREE_ONE) begin
                                n_status = ST_ONLY;
                                n_head   = NIL;
                                n_tail   = NIL;
                                nc       = NIL;
                            end else if (!is_slot(nxt_rd)) begin
                                // tail removed: cut the link, wrap cursor to head
                                n_status = ST_LAST;
                                if (is_slot(prv_rd)) begin
                                    mem_ctl.nxt_we = 1'b1;
                                    nxt_waddr      = prv_rd[SW-1:0];
                                    nxt_wdata      = NIL;
                                end
                                n_tail = prv_rd;
                                nc     = r_head;
                            end else begin
                                // bridge the neighbors, advance the cursor
                                n_status       = ST_DELETED;
                                mem_ctl.prv_we = 1'b1;
                                prv_waddr      = nxt_rd[SW-1:0];
                                prv_wdata      = prv_rd;
                                if (is_slot(prv_rd)) begin
                                    mem_ctl.nxt_we = 1'b1;
                                    nxt_waddr      = prv_rd[SW-1:0];
                                    nxt_wdata      = nxt_rd;
                                end
                                if (r_head == r_cursor) begin
                                    n_head = nxt_rd;
                                end
                                nc = nxt_rd;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                n_cursor       = nc;
                mem_ctl.trk_re = 1'b1;
                trk_raddr      = nc[SW-1:0];
            end
            S_TRK: begin
                // finish the append: old tail points at the new slot
                n_state = S_IDLE;
                if (r_pend_we) begin
                    mem_ctl.nxt_we = 1'b1;
                    nxt_waddr      = r_pend_addr;
                    nxt_wdata      = r_pend_data;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= NIL;
            r_tail    <= NIL;
            r_cursor  <= NIL;
            r_free    <= FREE_ALL;
            r_low     <= FREE_ALL;
            r_pend_we <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_cursor  <= n_cursor;
            r_free    <= n_free;
            r_low     <= n_low;
            r_pend_we <= n_pend_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_id        <= n_id;
        r_status    <= n_status;
        r_use_id    <= n_use_id;
        r_pend_addr <= n_pend_addr;
        r_pend_data <= n_pend_data;
    end

    // result: zero with no cursor; a fresh insert shows the held identifier, otherwise the read track
    assign play_sel   = !is_slot(r_cursor) ? '0 : (r_use_id ? r_id : trk_rd);
    assign play_wide  = {32'd0, play_sel};
    assign count      = FREE_ALL - r_free;
    assign count_wide = {7'd0, count};

    assign busy          = (r_state != S_IDLE);
    assign o_done        = (r_state == S_TRK);
    assign o_playing_id  = play_wide[31:0];
    assign o_list_empty  = !is_slot(r_head);
    assign o_status      = r_status;
    assign o_entry_count = count_wide[6:0];

endmodule
